// ----- src/mfek_pkg.sv -----
// ----------------------------------------------------------------------------
// mfek_pkg
// Shared types and codes for the Edmonds-Karp max-flow block.
// ----------------------------------------------------------------------------
package mfek_pkg;

   localparam int NODE_W     = 8;
   localparam int NODE_SPACE = 256;
   localparam int NC_W       = 9;
   localparam int CAP_IN_W   = 16;
   localparam int FLOW_OUT_W = 27;
   localparam int CSR_IDX_W  = 2;

   // commands
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_FLOW  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SINK   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NODES  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 2'd3;

   typedef struct packed {
      logic [1:0]          command;
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
      logic [CAP_IN_W-1:0] capacity;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [FLOW_OUT_W-1:0] max_flow;
   } rsp_type;

endpackage

// ----- src/mfek_ram.sv -----
// ----------------------------------------------------------------------------
// mfek_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mfek_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/mfek_edge_mem.sv -----
// ----------------------------------------------------------------------------
// mfek_edge_mem
// Edge pair store: endpoints and capacity, plus the signed flow of the
// forward edge of each pair. Registered read of both at one address.
// ----------------------------------------------------------------------------
module mfek_edge_mem #(
   parameter int PAIRS   = 1024,
   parameter int CAP_W   = 16
) (
   input  logic                            clock,
   input  logic [$clog2(PAIRS)-1:0]        addr,
   input  logic                            geo_we,
   input  logic [2*mfek_pkg::NODE_W+CAP_W-1:0] geo_wdata,
   input  logic                            flow_we,
   input  logic [CAP_W:0]                  flow_wdata,
   output logic [2*mfek_pkg::NODE_W+CAP_W-1:0] geo_rdata,
   output logic [CAP_W:0]                  flow_rdata
);

   localparam int GEO_W = 2 * mfek_pkg::NODE_W + CAP_W;

   logic [GEO_W-1:0] geo_mem  [PAIRS];
   logic [CAP_W:0]   flow_mem [PAIRS];
   logic [GEO_W-1:0] geo_rdata_ff;
   logic [CAP_W:0]   flow_rdata_ff;

   always_ff @(posedge clock) begin
      if (geo_we) begin
         geo_mem[addr] <= geo_wdata;
      end
      if (flow_we) begin
         flow_mem[addr] <= flow_wdata;
      end
      geo_rdata_ff  <= geo_mem[addr];
      flow_rdata_ff <= flow_mem[addr];
   end

   assign geo_rdata  = geo_rdata_ff;
   assign flow_rdata = flow_rdata_ff;

endmodule

// ----- src/max_flow_edmonds_karp.sv -----
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp
// Undirected max-flow engine: edges loaded one per word, run command does
// repeated breadth-first searches and augmentations over the edge store.
// ----------------------------------------------------------------------------
// add / clear / range-error words: result registered in S_EMIT once the output is free.
// run: clears the stored flows, then repeats search and augmentation until no
//   path is left, then sums the flow out of the source; one edge pair is read
//   from the edge store per cycle in the search and sum passes.
// one word at a time; reset (synchronous) empties the edge table, restores
//   source 0, sink 1, node count 256; no clearing pass is needed.
module max_flow_edmonds_karp #(
   parameter int MAX_EDGES = 1024,
   parameter int CAP_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  mfek_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output mfek_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mfek_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mfek_pkg::NC_W-1:0]              csr_data
);

   localparam int PAIR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int PAIRS  = 1 << PAIR_W;
   localparam int EC_W   = $clog2(MAX_EDGES + 1);
   localparam int DIR_W  = PAIR_W + 1;
   localparam int F_W    = CAP_WIDTH + 1;
   localparam int SUM_W  = PAIR_W + CAP_WIDTH + 3;
   localparam int NW     = mfek_pkg::NODE_W;
   localparam int GEO_W  = 2 * NW + CAP_WIDTH;

   typedef enum logic [3:0] {
      S_IDLE, S_EMIT, S_CLEAR, S_BFS_INIT, S_DEQ, S_DEQW, S_SCAN,
      S_WALK_P, S_WALK_E, S_WALK_D, S_SUM
   } state_type;

   state_type                state_ff;
   logic [NW-1:0]            source_ff, sink_ff;
   logic [mfek_pkg::NC_W-1:0] nodes_ff;
   logic [EC_W-1:0]          ec_ff, k_ff;
   logic                     rd_valid_ff;
   logic [PAIR_W-1:0]        rd_k_ff;
   logic [NW-1:0]            u_ff, v_ff;
   logic [NW:0]              head_ff, tail_ff;
   logic [mfek_pkg::NODE_SPACE-1:0] visited_ff;
   logic [DIR_W-1:0]         e_ff;
   logic [F_W-1:0]           neck_ff;
   logic                     pass2_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   mfek_pkg::rsp_type        res_ff;
   logic                     rsp_valid_ff;
   mfek_pkg::rsp_type        rsp_data_ff;

   // memory ports
   logic [PAIR_W-1:0] e_addr;
   logic              geo_we, flow_we;
   logic [GEO_W-1:0]  geo_wdata, geo_rdata;
   logic [F_W-1:0]    flow_wdata, flow_rdata;
   logic [NW-1:0]     p_addr, q_addr, q_wdata, q_rdata;
   logic              p_we, q_we;
   logic [DIR_W-1:0]  p_rdata;

   logic [mfek_pkg::NC_W-1:0] nn;
   logic              accept, add_ok, a_in, b_in, issue;
   logic [NW-1:0]     rd_a, rd_b;
   logic [CAP_WIDTH-1:0] rd_cap;
   logic [F_W-1:0]    r0, r1, resid, flow_new;
   logic              hit0, hit1, hit, found;
   logic [NW-1:0]     hit_v, from_v;
   logic [DIR_W-1:0]  hit_e;
   logic signed [SUM_W-1:0] term, f_ext;

   assign nn = (32'(nodes_ff) > mfek_pkg::NODE_SPACE)
               ? mfek_pkg::NC_W'(mfek_pkg::NODE_SPACE) : nodes_ff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign a_in   = ({1'b0, req_data.node_a} < nn);
   assign b_in   = ({1'b0, req_data.node_b} < nn);
   assign add_ok = a_in && b_in && (32'(ec_ff) < MAX_EDGES);
   assign issue  = (k_ff < ec_ff);

   assign rd_a   = geo_rdata[GEO_W-1 -: NW];
   assign rd_b   = geo_rdata[CAP_WIDTH +: NW];
   assign rd_cap = geo_rdata[CAP_WIDTH-1:0];

   // residuals of the forward and backward edge of the pair read
   assign r0 = {1'b0, rd_cap} - flow_rdata;
   assign r1 = {1'b0, rd_cap} + flow_rdata;

   assign hit0 = rd_valid_ff && (rd_a == u_ff) && ({1'b0, rd_b} < nn)
                 && !visited_ff[rd_b] && (r0 != '0);
   assign hit1 = rd_valid_ff && !hit0 && (rd_b == u_ff) && ({1'b0, rd_a} < nn)
                 && !visited_ff[rd_a] && (r1 != '0);
   assign hit   = hit0 || hit1;
   assign hit_v = hit0 ? rd_b : rd_a;
   assign hit_e = {rd_k_ff, hit1};
   assign found = hit && (hit_v == sink_ff);

   assign from_v   = e_ff[0] ? rd_b : rd_a;
   assign resid    = e_ff[0] ? r1 : r0;
   assign flow_new = e_ff[0] ? (flow_rdata - neck_ff) : (flow_rdata + neck_ff);

   // net contribution of a pair to the flow out of the source
   assign f_ext = SUM_W'($signed(flow_rdata));
   always_comb begin
      term = '0;
      if (rd_a == source_ff && rd_b != source_ff) begin
         term = f_ext;
      end else if (rd_b == source_ff && rd_a != source_ff) begin
         term = -f_ext;
      end
   end

   always_comb begin
      e_addr     = k_ff[PAIR_W-1:0];
      geo_we     = 1'b0;
      flow_we    = 1'b0;
      geo_wdata  = {req_data.node_a, req_data.node_b, CAP_WIDTH'(req_data.capacity)};
      flow_wdata = '0;
      case (state_ff)
         S_IDLE: begin
            e_addr  = ec_ff[PAIR_W-1:0];
            geo_we  = accept && (req_data.command == mfek_pkg::CMD_ADD) && add_ok;
            flow_we = geo_we;
         end
         S_CLEAR:  flow_we = issue;
         S_WALK_E: e_addr = p_rdata[DIR_W-1:1];
         S_WALK_D: begin
            e_addr     = e_ff[DIR_W-1:1];
            flow_we    = pass2_ff;
            flow_wdata = flow_new;
         end
         default: ;
      endcase
   end

   assign p_addr = (state_ff == S_SCAN) ? hit_v : v_ff;
   assign p_we   = (state_ff == S_SCAN) && hit;

   always_comb begin
      q_addr  = head_ff[NW-1:0];
      q_we    = 1'b0;
      q_wdata = hit_v;
      case (state_ff)
         S_BFS_INIT: begin
            q_addr  = '0;
            q_we    = 1'b1;
            q_wdata = source_ff;
         end
         S_SCAN: begin
            q_addr = tail_ff[NW-1:0];
            q_we   = hit && !found;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         source_ff    <= '0;
         sink_ff      <= NW'(1);
         nodes_ff     <= mfek_pkg::NC_W'(256);
         ec_ff        <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               mfek_pkg::CSR_SOURCE: source_ff <= csr_data[NW-1:0];
               mfek_pkg::CSR_SINK:   sink_ff   <= csr_data[NW-1:0];
               mfek_pkg::CSR_NODES:  nodes_ff  <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  res_ff   <= '{status: mfek_pkg::ST_OK, max_flow: '0};
                  state_ff <= S_EMIT;
                  case (req_data.command)
                     mfek_pkg::CMD_ADD: begin
                        if (!a_in || !b_in) begin
                           res_ff.status <= mfek_pkg::ST_RANGE;
                        end else if (!add_ok) begin
                           res_ff.status <= mfek_pkg::ST_FULL;
                        end else begin
                           ec_ff <= ec_ff + 1'b1;
                        end
                     end
                     mfek_pkg::CMD_RUN: begin
                        if ({1'b0, source_ff} >= nn || {1'b0, sink_ff} >= nn) begin
                           res_ff.status <= mfek_pkg::ST_RANGE;
                        end else begin
                           k_ff     <= '0;
                           state_ff <= S_CLEAR;
                        end
                     end
                     mfek_pkg::CMD_CLEAR: ec_ff <= '0;
                     default: ;
                  endcase
               end
            end
            S_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            S_CLEAR: begin
               if (issue) begin
                  k_ff <= k_ff + 1'b1;
               end else if (source_ff == sink_ff) begin
                  res_ff   <= '{status: mfek_pkg::ST_FLOW, max_flow: '0};
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_BFS_INIT;
               end
            end
            S_BFS_INIT: begin
               visited_ff            <= '0;
               visited_ff[source_ff] <= 1'b1;
               head_ff               <= '0;
               tail_ff               <= (NW+1)'(1);
               state_ff              <= S_DEQ;
            end
            S_DEQ: begin
               if (head_ff == tail_ff) begin
                  // no path left: total up the flow out of the source
                  k_ff        <= '0;
                  sum_ff      <= '0;
                  rd_valid_ff <= 1'b0;
                  state_ff    <= S_SUM;
               end else begin
                  head_ff  <= head_ff + 1'b1;
                  state_ff <= S_DEQW;
               end
            end
            S_DEQW: begin
               u_ff        <= q_rdata;
               k_ff        <= '0;
               rd_valid_ff <= 1'b0;
               state_ff    <= S_SCAN;
            end
            S_SCAN: begin
               rd_valid_ff <= issue;
               rd_k_ff     <= k_ff[PAIR_W-1:0];
               if (issue) begin
                  k_ff <= k_ff + 1'b1;
               end
               if (hit) begin
                  visited_ff[hit_v] <= 1'b1;
                  if (!found) begin
                     tail_ff <= tail_ff + 1'b1;
                  end
               end
               if (found) begin
                  v_ff        <= sink_ff;
                  neck_ff     <= '1;
                  pass2_ff    <= 1'b0;
                  rd_valid_ff <= 1'b0;
                  state_ff    <= S_WALK_P;
               end else if (!issue && !rd_valid_ff) begin
                  state_ff <= S_DEQ;
               end
            end
            S_WALK_P: state_ff <= S_WALK_E;
            S_WALK_E: begin
               e_ff     <= p_rdata;
               state_ff <= S_WALK_D;
            end
            S_WALK_D: begin
               if (!pass2_ff && resid < neck_ff) begin
                  neck_ff <= resid;
               end
               v_ff     <= from_v;
               state_ff <= S_WALK_P;
               if (from_v == source_ff) begin
                  if (!pass2_ff) begin
                     // bottleneck known: walk the path again to augment
                     pass2_ff <= 1'b1;
                     v_ff     <= sink_ff;
                  end else begin
                     state_ff <= S_BFS_INIT;
                  end
               end
            end
            S_SUM: begin
               rd_valid_ff <= issue;
               if (issue) begin
                  k_ff <= k_ff + 1'b1;
               end
               if (rd_valid_ff) begin
                  sum_ff <= sum_ff + term;
               end
               if (!issue && !rd_valid_ff) begin
                  res_ff.status   <= mfek_pkg::ST_FLOW;
                  res_ff.max_flow <= sum_ff[SUM_W-1] ? '0
                                     : mfek_pkg::FLOW_OUT_W'(unsigned'(sum_ff));
                  state_ff        <= S_EMIT;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   mfek_edge_mem #(
      .PAIRS (PAIRS),
      .CAP_W (CAP_WIDTH)
   ) u_edge_mem (
      .clock      (clock),
      .addr       (e_addr),
      .geo_we     (geo_we),
      .geo_wdata  (geo_wdata),
      .flow_we    (flow_we),
      .flow_wdata (flow_wdata),
      .geo_rdata  (geo_rdata),
      .flow_rdata (flow_rdata)
   );

   mfek_ram #(
      .WIDTH (DIR_W),
      .DEPTH (mfek_pkg::NODE_SPACE)
   ) u_parent_mem (
      .clock (clock),
      .addr  (p_addr),
      .we    (p_we),
      .wdata (hit_e),
      .rdata (p_rdata)
   );

   mfek_ram #(
      .WIDTH (NW),
      .DEPTH (mfek_pkg::NODE_SPACE)
   ) u_queue_mem (
      .clock (clock),
      .addr  (q_addr),
      .we    (q_we),
      .wdata (q_wdata),
      .rdata (q_rdata)
   );

endmodule

// ----- src/mfek_checker.sv -----
// ----------------------------------------------------------------------------
// mfek_port_checks
// Port-level checks for the max-flow block, bound to the top level.
// ----------------------------------------------------------------------------
module mfek_port_checks (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mfek_pkg::rsp_type rsp_data
);

   // nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one word in flight: the input closes after each accept
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while busy");

   // only a flow result carries a flow value
   a_flow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != mfek_pkg::ST_FLOW |-> rsp_data.max_flow == '0)
      else $error("flow value on non-flow result");

endmodule

bind max_flow_edmonds_karp mfek_port_checks u_mfek_port_checks (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
